// File: design/digit_trie_prefix_checker_assert.svh
// assertion macros for the digit trie prefix checker
// no dependencies, included inside the top level module body
`ifndef DIGIT_TRIE_PREFIX_CHECKER_ASSERT_SVH
`define DIGIT_TRIE_PREFIX_CHECKER_ASSERT_SVH

// generic clocked assertion with active-low reset
`define DTPC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define DTPC_ASSERT(lbl, prop, msg) \
  `DTPC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: design/dtpc_pkg.sv
// shared types and constants for the digit trie prefix checker
// no dependencies
`timescale 1ns / 1ps

package dtpc_pkg;

  localparam int unsigned NODE_COUNT_DEF = 4096;
  localparam int unsigned RADIX_DEF      = 10;
  localparam int unsigned DIGIT_W        = 4;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               first_of_set;
    logic               last_of_number;
  } in_t;

  typedef struct packed {
    logic prefix_conflict;
    logic table_full;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_ALLOC,
    ST_RD_END,
    ST_FIN
  } state_e;

endpackage

// File: design/digit_trie_prefix_checker.sv
// digit trie prefix checker top level: sequencer, node store and child pointer store
// depends on dtpc_pkg and digit_trie_prefix_checker_assert.svh
`timescale 1ns / 1ps

// channel | valid      | stall       | payload
// request | in_valid_i | in_stall_o  | in_data_i  (in_t)
// result  | out_valid_o| out_stall_i | out_data_o (out_t)
//
// a digit is accepted, the node store is read, then the digit is evaluated; allocating
// a node adds a step, and a number that ends after following an existing edge adds a
// second node store read, as the node store read port has registered read data
// reset clears the root node, flags and allocator at once, so no clearing pass is needed
// a result waiting under out_stall_i holds the sequencer only at the step that emits
// in_stall_o is high whenever a request is in progress

module digit_trie_prefix_checker
  import dtpc_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF,
  parameter int unsigned RADIX      = RADIX_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned NodeW  = $clog2(NODE_COUNT);
  localparam int unsigned FreeW  = NodeW + 1;
  localparam int unsigned SlotN  = NODE_COUNT * RADIX;
  localparam int unsigned SlotW  = $clog2(SlotN);
  localparam int unsigned DigW   = $clog2(RADIX);
  localparam int unsigned DigCmpW = DIGIT_W + 1;

  state_e              state_q, state_d;
  in_t                 item_q, item_d;
  logic [NodeW-1:0]    cur_q, cur_d;
  logic [FreeW-1:0]    free_q, free_d;
  logic                conflict_q, conflict_d;
  logic                full_q, full_d;
  logic [RADIX-1:0]    root_mask_q, root_mask_d;
  logic                root_end_q, root_end_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic [RADIX:0]      node_mem [NODE_COUNT];
  logic [NodeW-1:0]    child_mem [SlotN];
  logic [RADIX:0]      node_rdata_q;
  logic [NodeW-1:0]    child_rdata_q;
  logic                node_rd_en, child_rd_en;
  logic                node_we, child_we;
  logic [NodeW-1:0]    node_waddr;
  logic [RADIX:0]      node_wdata;
  logic [SlotW-1:0]    slot;

  logic                accept, out_free, at_root;
  logic [RADIX-1:0]    info_mask, dig_bit;
  logic                info_end, end_conf;
  logic [DigW-1:0]     didx;
  logic                dig_ok, hit, alloc_ok, do_alloc, emit_ev, full_ev, conf_ev;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign at_root  = (cur_q == '0);

  assign didx      = item_q.digit[DigW-1:0];
  assign dig_bit   = RADIX'(1) << didx;
  assign dig_ok    = DigCmpW'(item_q.digit) < DigCmpW'(RADIX);
  assign slot      = SlotW'(cur_q) * SlotW'(RADIX) + SlotW'(item_q.digit);
  assign info_mask = at_root ? root_mask_q : node_rdata_q[RADIX:1];
  assign info_end  = at_root ? root_end_q : node_rdata_q[0];
  assign end_conf  = info_end || (info_mask != '0);
  assign hit       = info_mask[didx];
  assign alloc_ok  = free_q < FreeW'(NODE_COUNT);
  assign do_alloc  = dig_ok && !hit && alloc_ok;
  assign full_ev   = full_q || (dig_ok && !hit && !alloc_ok);
  assign conf_ev   = conflict_q || (dig_ok && info_end);
  assign emit_ev   = item_q.last_of_number && (!dig_ok || (!hit && !alloc_ok));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_EV;
      ST_EV: begin
        if (emit_ev) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else if (do_alloc) begin
          state_d = ST_ALLOC;
        end else if (item_q.last_of_number) begin
          state_d = ST_RD_END;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        if (!item_q.last_of_number || out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_END: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    item_d      = item_q;
    cur_d       = cur_q;
    free_d      = free_q;
    conflict_d  = conflict_q;
    full_d      = full_q;
    root_mask_d = root_mask_q;
    root_end_d  = root_end_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    node_rd_en  = 1'b0;
    child_rd_en = 1'b0;
    node_we     = 1'b0;
    child_we    = 1'b0;
    node_waddr  = cur_q;
    node_wdata  = {info_mask, info_end};
    in_stall_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          if (in_data_i.first_of_set) begin
            cur_d       = '0;
            free_d      = FreeW'(1);
            conflict_d  = 1'b0;
            full_d      = 1'b0;
            root_mask_d = '0;
            root_end_d  = 1'b0;
          end
        end
      end
      ST_RD: begin
        node_rd_en  = 1'b1;
        child_rd_en = dig_ok;
      end
      ST_EV: begin
        if (!emit_ev || out_free) begin
          conflict_d = conf_ev;
          full_d     = full_ev;
          if (dig_ok && hit) begin
            cur_d = child_rdata_q;
          end
          if (do_alloc) begin
            child_we = 1'b1;
            if (at_root) begin
              root_mask_d = info_mask | dig_bit;
            end else begin
              node_we    = 1'b1;
              node_wdata = {info_mask | dig_bit, info_end};
            end
          end
          if (emit_ev) begin
            conflict_d = conf_ev || end_conf;
            if (at_root) begin
              root_end_d = 1'b1;
            end else begin
              node_we    = 1'b1;
              node_wdata = {info_mask, 1'b1};
            end
            out_valid_d           = 1'b1;
            out_d.prefix_conflict = conf_ev || end_conf;
            out_d.table_full      = full_ev;
            cur_d                 = '0;
          end
        end
      end
      ST_ALLOC: begin
        if (!item_q.last_of_number || out_free) begin
          node_we    = 1'b1;
          node_waddr = free_q[NodeW-1:0];
          node_wdata = {{RADIX{1'b0}}, item_q.last_of_number};
          free_d     = free_q + FreeW'(1);
          if (item_q.last_of_number) begin
            out_valid_d           = 1'b1;
            out_d.prefix_conflict = conflict_q;
            out_d.table_full      = full_q;
            cur_d                 = '0;
          end else begin
            cur_d = free_q[NodeW-1:0];
          end
        end
      end
      ST_RD_END: begin
        node_rd_en = 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          conflict_d = conflict_q || end_conf;
          if (at_root) begin
            root_end_d = 1'b1;
          end else begin
            node_we    = 1'b1;
            node_wdata = {info_mask, 1'b1};
          end
          out_valid_d           = 1'b1;
          out_d.prefix_conflict = conflict_q || end_conf;
          out_d.table_full      = full_q;
          cur_d                 = '0;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      free_q      <= FreeW'(1);
      conflict_q  <= 1'b0;
      full_q      <= 1'b0;
      root_mask_q <= '0;
      root_end_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      free_q      <= free_d;
      conflict_q  <= conflict_d;
      full_q      <= full_d;
      root_mask_q <= root_mask_d;
      root_end_q  <= root_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  // node store: child mask and end mark per node
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_rd_en) begin
      node_rdata_q <= node_mem[cur_q];
    end
  end

  // child pointer store, one entry per node and digit
  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[slot] <= free_q[NodeW-1:0];
    end
    if (child_rd_en) begin
      child_rdata_q <= child_mem[slot];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "digit_trie_prefix_checker_assert.svh"

  `DTPC_ASSERT(a_free_bound, free_q <= FreeW'(NODE_COUNT), "allocator ran past the node store")
  `DTPC_ASSERT(a_cur_allocated, cur_q < free_q, "current node is not an allocated node")
  `DTPC_ASSERT(a_result_source, $rose(out_valid_q) |-> ($past(state_q) == ST_EV || $past(state_q) == ST_ALLOC || $past(state_q) == ST_FIN), "result raised outside an ending step")
  `DTPC_ASSERT(a_full_sticky, full_q && !(accept && in_data_i.first_of_set) |=> full_q, "full flag dropped within a set")

endmodule

// File: sim/tb_digit_trie_prefix_checker.sv
// testbench for digit_trie_prefix_checker: directed sets and random sets
// keeps its own trie of the digits sent and checks every result against it
// depends on dtpc_pkg and the design sources only
`timescale 1ns / 1ps

module tb_digit_trie_prefix_checker;
  import dtpc_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 780;

  class trie_scoreboard;
    typedef logic [11:0] node_t;

    node_t                child_ptr [NODE_COUNT_DEF*RADIX_DEF];
    logic [RADIX_DEF-1:0] child_mask [NODE_COUNT_DEF];
    logic                 end_mark [NODE_COUNT_DEF];
    logic [12:0]          free_node;
    node_t                at_node;
    logic                 conflict;
    logic                 full;
    out_t                 expected_flags [$];
    int unsigned          fails;

    function new();
      foreach (child_mask[i]) begin
        child_mask[i] = '0;
        end_mark[i]   = 1'b0;
      end
      fails = 0;
      clear_set();
    endfunction

    function void clear_set();
      child_mask[0] = '0;
      end_mark[0]   = 1'b0;
      free_node     = 13'd1;
      at_node       = '0;
      conflict      = 1'b0;
      full          = 1'b0;
    endfunction

    function void step_down(logic [DIGIT_W-1:0] d);
      int unsigned slot;
      slot = at_node * RADIX_DEF + d;
      if (end_mark[at_node]) conflict = 1'b1;
      if (child_mask[at_node][d]) begin
        at_node = child_ptr[slot];
      end else if (free_node >= NODE_COUNT_DEF) begin
        full = 1'b1;
      end else begin
        child_mask[free_node]      = '0;
        end_mark[free_node]        = 1'b0;
        child_ptr[slot]            = free_node[11:0];
        child_mask[at_node][d]     = 1'b1;
        at_node                    = free_node[11:0];
        free_node                  = free_node + 13'd1;
      end
    endfunction

    function void note_request(in_t req);
      out_t flags;
      if (req.first_of_set) clear_set();
      if (req.digit < RADIX_DEF) step_down(req.digit);
      if (req.last_of_number) begin
        if (end_mark[at_node] || child_mask[at_node] != '0) conflict = 1'b1;
        end_mark[at_node]     = 1'b1;
        flags.prefix_conflict = conflict;
        flags.table_full      = full;
        expected_flags.push_back(flags);
        at_node = '0;
      end
    endfunction

    function void report(string what);
      fails++;
      if (fails <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_flags.size() == 0) begin
        report($sformatf("unexpected result conflict %0b full %0b",
                         got.prefix_conflict, got.table_full));
        return;
      end
      want = expected_flags.pop_front();
      if (got.prefix_conflict !== want.prefix_conflict ||
          got.table_full !== want.table_full)
        report($sformatf("prefix_conflict exp %0b got %0b, table_full exp %0b got %0b",
                         want.prefix_conflict, got.prefix_conflict,
                         want.table_full, got.table_full));
    endfunction

    function int unsigned pending();
      return expected_flags.size();
    endfunction

    function void finish_check();
      if (expected_flags.size() != 0)
        report($sformatf("%0d results never arrived", expected_flags.size()));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;

  trie_scoreboard sb = new();
  bit             quiet;
  int unsigned    sent_items;
  int unsigned    stall_left;
  int unsigned    idle_cycles;

  digit_trie_prefix_checker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIGIT_W-1:0] rand_digit(int unsigned alpha);
    if ($urandom_range(0, 29) == 0) return DIGIT_W'($urandom_range(RADIX_DEF, 15));
    return DIGIT_W'($urandom_range(0, alpha - 1));
  endfunction

  task automatic send_digit(logic [DIGIT_W-1:0] d, logic first, logic last);
    int unsigned gap;
    in_t         req;
    gap = pick_gap();
    req = '{digit: d, first_of_set: first, last_of_number: last};
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    sent_items++;
  endtask

  task automatic send_number(int unsigned len, int unsigned alpha, logic first);
    for (int unsigned i = 0; i < len; i++)
      send_digit(rand_digit(alpha), first && i == 0, i == len - 1);
  endtask

  // sender holds off until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // result side: check and stall
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (stall_left != 0) stall_left--;
      else if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned start;
    int unsigned n_numbers;
    int unsigned alpha;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet      = 1'b0;
    sent_items = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shorter number first: 12 then 123
    send_digit(4'd1, 1'b1, 1'b0);
    send_digit(4'd2, 1'b0, 1'b1);
    send_digit(4'd1, 1'b0, 1'b0);
    send_digit(4'd2, 1'b0, 1'b0);
    send_digit(4'd3, 1'b0, 1'b1);
    // longer number first: 555 then 55
    send_digit(4'd5, 1'b1, 1'b0);
    send_digit(4'd5, 1'b0, 1'b0);
    send_digit(4'd5, 1'b0, 1'b1);
    send_digit(4'd5, 1'b0, 1'b0);
    send_digit(4'd5, 1'b0, 1'b1);
    // exact duplicate
    send_digit(4'd7, 1'b1, 1'b1);
    send_digit(4'd7, 1'b0, 1'b1);
    // extreme digits, no conflict
    send_digit(4'd0, 1'b1, 1'b1);
    send_digit(4'd9, 1'b0, 1'b1);
    // empty number at the root, then any number after it
    send_digit(4'd15, 1'b1, 1'b1);
    send_digit(4'd3, 1'b0, 1'b1);
    // new set starting in the middle of a number
    send_digit(4'd4, 1'b1, 1'b0);
    send_digit(4'd8, 1'b1, 1'b1);
    send_digit(4'd4, 1'b0, 1'b0);
    send_digit(4'd8, 1'b0, 1'b1);
    // out of range digit inside a number
    send_digit(4'd2, 1'b0, 1'b0);
    send_digit(4'd10, 1'b0, 1'b0);
    send_digit(4'd6, 1'b0, 1'b1);
    drain();

    start = sent_items;
    while (sent_items - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: send_digit(DIGIT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        1: drain();
        default: begin
          quiet     = ($urandom_range(0, 5) == 0);
          n_numbers = $urandom_range(1, 8);
          case ($urandom_range(0, 2))
            0: alpha = 2;
            1: alpha = 3;
            default: alpha = RADIX_DEF;
          endcase
          send_number($urandom_range(1, 5), alpha, 1'b1);
          for (int unsigned k = 1; k < n_numbers; k++)
            send_number($urandom_range(1, 5), alpha, 1'b0);
        end
      endcase
    end
    quiet = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);
    sb.finish_check();
    if (sb.fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: digit_trie_prefix_checker.f
+incdir+design
design/dtpc_pkg.sv
design/digit_trie_prefix_checker.sv
sim/tb_digit_trie_prefix_checker.sv
